>>> hw/rtl/pkth_pkg.sv
// Shared types and constants for the code-address keyed trace hash table.
// Used by pkth_ctrl, pkth_dp and pc_keyed_trace_hash_table; no dependencies.
`timescale 1ns / 1ps

package pkth_pkg;

	localparam int SLOTS_DEF       = 64;
	localparam int KEY_BITS_DEF    = 48;
	localparam int HANDLE_BITS_DEF = 16;

	localparam logic [31:0] FIB_MULT   = 32'd2654435761;
	localparam int          LOAD_NUM   = 7;
	localparam int          LOAD_DEN   = 10;
	localparam int          ADDR_SHIFT = 2;

	localparam logic KIND_LOOKUP = 1'b0;
	localparam logic KIND_STORE  = 1'b1;

	typedef enum logic [2:0] {
		ST_HIT      = 3'd0,
		ST_MISS     = 3'd1,
		ST_INSERTED = 3'd2,
		ST_REPLACED = 3'd3,
		ST_FULL     = 3'd4,
		ST_ZERO     = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_CHECK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic    load_in;
		logic    clear_wr;
		logic    advance;
		logic    finish;
		status_t code;
		logic    write;
		logic    insert;
		logic    load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic kind;
		logic key_zero;
		logic count_zero;
		logic empty;
		logic match;
		logic off;
		logic last;
		logic at_limit;
		logic clear_last;
	} dp_status_t;

endpackage

>>> hw/rtl/pkth_ctrl.sv
// Controller of the trace hash table: clearing sweep, probe sequencing and result handoff.
// Depends on pkth_pkg for the state, command and status types.
`timescale 1ns / 1ps

module pkth_ctrl
	import pkth_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t st,
	output dp_cmd_t    cmd,
	output state_t     state
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (st.clear_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_d = S_READ;
			end
			S_READ: begin
				state_d = cmd.finish ? S_DONE : S_CHECK;
			end
			S_CHECK: begin
				if (cmd.finish) state_d = S_DONE;
			end
			S_DONE: begin
				if (cmd.load_out) state_d = S_IDLE;
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.code = ST_MISS;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear_wr = 1'b1;
			end
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			S_READ: begin
				if (st.kind == KIND_LOOKUP && st.count_zero) begin
					cmd.finish = 1'b1;
					cmd.code   = ST_MISS;
				end else if (st.kind == KIND_STORE && st.key_zero) begin
					cmd.finish = 1'b1;
					cmd.code   = ST_ZERO;
				end
			end
			S_CHECK: begin
				if (st.kind == KIND_LOOKUP) begin
					if (st.empty) begin
						cmd.finish = 1'b1;
						cmd.code   = ST_MISS;
					end else if (st.match) begin
						cmd.finish = 1'b1;
						cmd.code   = st.off ? ST_MISS : ST_HIT;
					end else if (st.last) begin
						cmd.finish = 1'b1;
						cmd.code   = ST_MISS;
					end else begin
						cmd.advance = 1'b1;
					end
				end else begin
					if (st.empty) begin
						cmd.finish = 1'b1;
						if (st.at_limit) begin
							cmd.code = ST_FULL;
						end else begin
							cmd.code   = ST_INSERTED;
							cmd.write  = 1'b1;
							cmd.insert = 1'b1;
						end
					end else if (st.match) begin
						cmd.finish = 1'b1;
						cmd.code   = ST_REPLACED;
						cmd.write  = 1'b1;
					end else if (st.last) begin
						cmd.finish = 1'b1;
						cmd.code   = ST_FULL;
					end else begin
						cmd.advance = 1'b1;
					end
				end
			end
			S_DONE: begin
				cmd.load_out = !out_valid_q || out_ready;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign state     = state_q;

endmodule

>>> hw/rtl/pkth_dp.sv
// Datapath of the trace hash table: slot memory, home-slot hash, probe index,
// occupancy count and result registers. Depends on pkth_pkg.
`timescale 1ns / 1ps

module pkth_dp
	import pkth_pkg::*;
#(
	parameter int SLOTS       = SLOTS_DEF,
	parameter int KEY_BITS    = KEY_BITS_DEF,
	parameter int HANDLE_BITS = HANDLE_BITS_DEF,
	localparam int SLOT_W     = $clog2(SLOTS),
	localparam int CNT_W      = SLOT_W + 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dp_cmd_t                cmd,
	output dp_status_t             st,
	input  logic                   kind,
	input  logic [KEY_BITS-1:0]    key,
	input  logic [HANDLE_BITS-1:0] handle,
	input  logic                   off_flag,
	output status_t                status,
	output logic [HANDLE_BITS-1:0] found_handle,
	output logic [SLOT_W-1:0]      slot,
	output logic [CNT_W-1:0]       entry_count
);

	localparam int LOAD_LIMIT = (SLOTS * LOAD_NUM + LOAD_DEN - 1) / LOAD_DEN;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

	logic [KEY_BITS-1:0]    mem_key    [SLOTS];
	logic [HANDLE_BITS-1:0] mem_handle [SLOTS];
	logic                   mem_off    [SLOTS];

	logic [KEY_BITS-1:0]    rd_key_q;
	logic [HANDLE_BITS-1:0] rd_handle_q;
	logic                   rd_off_q;

	logic                   kind_q;
	logic [KEY_BITS-1:0]    key_q;
	logic [HANDLE_BITS-1:0] handle_q;
	logic                   off_q;

	logic [SLOT_W-1:0]      idx_q;
	logic [SLOT_W-1:0]      probe_q;
	logic [CNT_W-1:0]       count_q;

	status_t                res_status_q;
	logic [HANDLE_BITS-1:0] res_handle_q;
	logic [SLOT_W-1:0]      res_slot_q;

	status_t                status_q;
	logic [HANDLE_BITS-1:0] found_handle_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [CNT_W-1:0]       entry_count_q;

	logic [SLOT_W-1:0]      key_lo;
	logic [SLOT_W-1:0]      mult_lo;
	logic [SLOT_W-1:0]      prod;
	logic [SLOT_W-1:0]      home;
	logic [SLOT_W-1:0]      idx_next;
	logic [SLOT_W-1:0]      rd_addr;
	logic                   we;
	logic [KEY_BITS-1:0]    wr_key;
	logic [HANDLE_BITS-1:0] wr_handle;
	logic                   wr_off;

	// home slot: only the low index bits of the product are kept
	assign key_lo   = key[ADDR_SHIFT +: SLOT_W];
	assign mult_lo  = FIB_MULT[SLOT_W-1:0];
	assign prod     = key_lo * mult_lo;
	assign home     = prod;
	assign idx_next = idx_q + SLOT_W'(1);
	assign rd_addr  = cmd.advance ? idx_next : idx_q;

	assign we        = cmd.clear_wr || cmd.write;
	assign wr_key    = cmd.clear_wr ? '0 : key_q;
	assign wr_handle = cmd.clear_wr ? '0 : handle_q;
	assign wr_off    = cmd.clear_wr ? 1'b0 : off_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_key[idx_q]    <= wr_key;
			mem_handle[idx_q] <= wr_handle;
			mem_off[idx_q]    <= wr_off;
		end
		rd_key_q    <= mem_key[rd_addr];
		rd_handle_q <= mem_handle[rd_addr];
		rd_off_q    <= mem_off[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			probe_q <= '0;
			count_q <= '0;
		end else begin
			if (cmd.load_in) begin
				idx_q   <= home;
				probe_q <= '0;
			end else if (cmd.clear_wr || cmd.advance) begin
				idx_q <= idx_next;
			end
			if (cmd.advance) probe_q <= probe_q + SLOT_W'(1);
			if (cmd.insert) count_q <= count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			kind_q   <= kind;
			key_q    <= key;
			handle_q <= handle;
			off_q    <= off_flag;
		end
		if (cmd.finish) begin
			res_status_q <= cmd.code;
			res_handle_q <= (cmd.code == ST_HIT) ? rd_handle_q : '0;
			case (cmd.code) inside
				ST_HIT, ST_INSERTED, ST_REPLACED: res_slot_q <= idx_q;
				default:                          res_slot_q <= '0;
			endcase
		end
		if (cmd.load_out) begin
			status_q       <= res_status_q;
			found_handle_q <= res_handle_q;
			slot_q         <= res_slot_q;
			entry_count_q  <= count_q;
		end
	end

	always_comb begin
		st            = '0;
		st.kind       = kind_q;
		st.key_zero   = (key_q == '0);
		st.count_zero = (count_q == '0);
		st.empty      = (rd_key_q == '0);
		st.match      = (rd_key_q == key_q);
		st.off        = rd_off_q;
		st.last       = (probe_q == LAST_SLOT);
		st.at_limit   = (count_q >= CNT_W'(LOAD_LIMIT));
		st.clear_last = (idx_q == LAST_SLOT);
	end

	assign status       = status_q;
	assign found_handle = found_handle_q;
	assign slot         = slot_q;
	assign entry_count  = entry_count_q;

endmodule

>>> hw/rtl/pc_keyed_trace_hash_table.sv
// Top level of the code-address keyed trace hash table.
// Instantiates pkth_ctrl and pkth_dp; depends on pkth_pkg.
`timescale 1ns / 1ps

// Open-addressing table of SLOTS entries mapping nonzero code addresses to
// trace handles, with a multiplicative home slot and linear probing. Each
// input transaction yields exactly one result transaction. After reset the
// table is cleared by a sweep over every slot during which in_ready stays low.
// A transaction then reads its home slot and probes one slot per cycle through
// the single table read port until a match, an empty slot or all slots probed;
// a lookup on an empty table or a store of key zero ends without probing. The
// result then passes to the output register. A new transaction is accepted
// while a finished result still waits on out_ready. New keys are refused once
// the count of occupied slots reaches 7/10 of SLOTS; replacement still works.

module pc_keyed_trace_hash_table
	import pkth_pkg::*;
#(
	parameter int SLOTS       = SLOTS_DEF,
	parameter int KEY_BITS    = KEY_BITS_DEF,
	parameter int HANDLE_BITS = HANDLE_BITS_DEF,
	localparam int SLOT_W     = $clog2(SLOTS),
	localparam int CNT_W      = SLOT_W + 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   kind,
	input  logic [KEY_BITS-1:0]    key,
	input  logic [HANDLE_BITS-1:0] handle,
	input  logic                   off_flag,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [2:0]             status,
	output logic [HANDLE_BITS-1:0] found_handle,
	output logic [SLOT_W-1:0]      slot,
	output logic [CNT_W-1:0]       entry_count
);

	localparam int LOAD_LIMIT = (SLOTS * LOAD_NUM + LOAD_DEN - 1) / LOAD_DEN;

	dp_cmd_t    cmd;
	dp_status_t st;
	state_t     state;

	pkth_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd),
		.state     (state)
	);

	pkth_dp #(
		.SLOTS       (SLOTS),
		.KEY_BITS    (KEY_BITS),
		.HANDLE_BITS (HANDLE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.kind         (kind),
		.key          (key),
		.handle       (handle),
		.off_flag     (off_flag),
		.status       (status),
		.found_handle (found_handle),
		.slot         (slot),
		.entry_count  (entry_count)
	);

`ifndef ASSERT_OFF
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entry_count <= CNT_W'(LOAD_LIMIT))
		else $error("entry count beyond load limit");

	a_handle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_HIT) |-> found_handle == '0)
		else $error("nonzero handle on a result other than a hit");

	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_MISS || status == ST_FULL || status == ST_ZERO))
			|-> slot == '0)
		else $error("nonzero slot on a miss or rejection");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state == S_READ)
		else $error("accepted transaction did not start a probe");
`endif

endmodule

>>> tb/tb.sv
// Self-checking testbench for pc_keyed_trace_hash_table: lookups and stores against a
// behavioral hash table, with random idle gaps on both valid/ready channels.
// Depends on pkth_pkg and the pc_keyed_trace_hash_table RTL.
`timescale 1ns / 1ps

module tb;
	import pkth_pkg::*;

	localparam int SLOTS       = SLOTS_DEF;
	localparam int KW          = KEY_BITS_DEF;
	localparam int HW          = HANDLE_BITS_DEF;
	localparam int SW          = $clog2(SLOTS);
	localparam int CW          = SW + 1;
	localparam int RANDOM_TXNS = 500;
	localparam int DRAIN       = 100;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic          kind;
		logic [KW-1:0] key;
		logic [HW-1:0] handle;
		logic          off;
	} txn_t;

	typedef struct {
		status_t       status;
		logic [HW-1:0] handle;
		logic [SW-1:0] slot;
		logic [CW-1:0] count;
	} lookup_result_t;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          in_valid  = 1'b0;
	logic          in_ready;
	logic          kind      = KIND_LOOKUP;
	logic [KW-1:0] key       = '0;
	logic [HW-1:0] handle    = '0;
	logic          off_flag  = 1'b0;
	logic          out_valid;
	logic          out_ready = 1'b0;
	logic [2:0]    status;
	logic [HW-1:0] found_handle;
	logic [SW-1:0] slot;
	logic [CW-1:0] entry_count;

	// behavioral copy of the table
	logic [KW-1:0] tbl_key    [SLOTS] = '{default: '0};
	logic [HW-1:0] tbl_handle [SLOTS] = '{default: '0};
	logic          tbl_off    [SLOTS] = '{default: 1'b0};
	int            occupied = 0;

	txn_t           txn_queue[$];
	lookup_result_t pending_results[$];
	txn_t           cur;
	int             send_gap = 0;
	int             recv_gap = 0;
	int             n_sent   = 0;
	int             n_seen   = 0;
	int             errors   = 0;
	int             cycles   = 0;

	pc_keyed_trace_hash_table DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.key         (key),
		.handle      (handle),
		.off_flag    (off_flag),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.found_handle(found_handle),
		.slot        (slot),
		.entry_count (entry_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [SW-1:0] home_of(logic [KW-1:0] k);
		logic [KW-1:0] shifted;
		logic [31:0]   h;
		shifted = k >> ADDR_SHIFT;
		h = shifted[31:0] * FIB_MULT;
		return h[SW-1:0];
	endfunction

	function automatic logic [KW-1:0] rand_key();
		return {16'($urandom), 32'($urandom)};
	endfunction

	function automatic int draw_gap(int n);
		return ((n / 40) % 3 == 1) ? 0 : $urandom_range(0, 10);
	endfunction

	function automatic lookup_result_t hash_table_apply(txn_t t);
		lookup_result_t r;
		logic [SW-1:0]  idx;
		logic           done;
		logic           at_limit;
		r.status = ST_MISS;
		r.handle = '0;
		r.slot   = '0;
		idx      = home_of(t.key);
		done     = 1'b0;
		if (t.kind == KIND_LOOKUP) begin
			if (occupied != 0) begin
				for (int i = 0; i < SLOTS && !done; i++) begin
					if (tbl_key[idx] == '0) begin
						done = 1'b1;
					end else if (tbl_key[idx] == t.key) begin
						done = 1'b1;
						if (!tbl_off[idx]) begin
							r.status = ST_HIT;
							r.handle = tbl_handle[idx];
							r.slot   = idx;
						end
					end else begin
						idx = idx + 1'b1;
					end
				end
			end
		end else if (t.key == '0) begin
			r.status = ST_ZERO;
		end else begin
			at_limit = occupied * LOAD_DEN >= SLOTS * LOAD_NUM;
			r.status = ST_FULL;
			for (int i = 0; i < SLOTS && !done; i++) begin
				if (tbl_key[idx] == '0) begin
					done = 1'b1;
					if (!at_limit) begin
						tbl_key[idx]    = t.key;
						tbl_handle[idx] = t.handle;
						tbl_off[idx]    = t.off;
						occupied++;
						r.status = ST_INSERTED;
						r.slot   = idx;
					end
				end else if (tbl_key[idx] == t.key) begin
					done = 1'b1;
					tbl_handle[idx] = t.handle;
					tbl_off[idx]    = t.off;
					r.status = ST_REPLACED;
					r.slot   = idx;
				end else begin
					idx = idx + 1'b1;
				end
			end
		end
		r.count = CW'(occupied);
		return r;
	endfunction

	task automatic queue_txn(logic k, logic [KW-1:0] a, logic [HW-1:0] h, logic o);
		txn_t t;
		t.kind   = k;
		t.key    = a;
		t.handle = h;
		t.off    = o;
		txn_queue.push_back(t);
	endtask

	always @(posedge clk) begin : drive
		logic nv;
		nv = in_valid;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				pending_results.push_back(hash_table_apply(cur));
				nv = 1'b0;
				n_sent++;
				send_gap = draw_gap(n_sent);
			end
			if (!nv && txn_queue.size() != 0) begin
				if (send_gap != 0) begin
					send_gap--;
				end else begin
					cur = txn_queue.pop_front();
					kind     <= cur.kind;
					key      <= cur.key;
					handle   <= cur.handle;
					off_flag <= cur.off;
					nv = 1'b1;
				end
			end
			in_valid <= nv;
		end
	end

	always @(posedge clk) begin : watch
		logic           nr;
		lookup_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				n_seen++;
				if (pending_results.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result: status %0d handle %h slot %0d count %0d",
							status, found_handle, slot, entry_count);
				end else begin
					want = pending_results.pop_front();
					if (status !== want.status || found_handle !== want.handle ||
							slot !== want.slot || entry_count !== want.count) begin
						errors++;
						if (errors <= 10)
							$display("result %0d mismatch: got %0d/%h/%0d/%0d want %0d/%h/%0d/%0d",
								n_seen, status, found_handle, slot, entry_count,
								want.status, want.handle, want.slot, want.count);
					end
				end
				recv_gap = draw_gap(n_seen);
			end
			if (recv_gap != 0) begin
				recv_gap--;
				nr = 1'b0;
			end else begin
				nr = 1'b1;
			end
			out_ready <= nr;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin : stimulus
		logic [KW-1:0] k63;
		logic [KW-1:0] k;
		logic [KW-1:0] pool[$];
		logic [KW-1:0] cluster[4];
		int            n_pool;
		int            pick;

		do begin
			k63 = rand_key();
			k63[KW-1] = 1'b0;
		end while (home_of(k63) != SW'(SLOTS - 1));
		for (int j = 0; j < 4; j++) begin
			cluster[j] = rand_key();
			cluster[j][KW-1] = 1'b0;
		end

		// directed: empty table, zero keys, extremes, wrap, collisions, disabled entries
		queue_txn(KIND_LOOKUP, rand_key(), '1, 1'b1);
		queue_txn(KIND_STORE, '0, '1, 1'b1);
		queue_txn(KIND_LOOKUP, '0, '0, 1'b0);
		queue_txn(KIND_STORE, '1, '1, 1'b0);
		queue_txn(KIND_LOOKUP, '1, '0, 1'b0);
		queue_txn(KIND_LOOKUP, '0, '1, 1'b1);
		queue_txn(KIND_STORE, k63, '0, 1'b0);
		queue_txn(KIND_STORE, k63 + 256, 16'h1234, 1'b0);
		queue_txn(KIND_STORE, k63 + 512, 16'h7777, 1'b1);
		queue_txn(KIND_LOOKUP, k63 + 256, '0, 1'b0);
		queue_txn(KIND_LOOKUP, k63 + 512, '0, 1'b0);
		queue_txn(KIND_STORE, k63 + 512, 16'h5555, 1'b0);
		queue_txn(KIND_LOOKUP, k63 + 512, '1, 1'b1);
		queue_txn(KIND_LOOKUP, k63 + 768, '0, 1'b0);
		queue_txn(KIND_STORE, k63, 16'hA5A5, 1'b1);
		queue_txn(KIND_LOOKUP, k63, '0, 1'b0);
		queue_txn(KIND_STORE, 48'h5, 16'h0001, 1'b0);
		queue_txn(KIND_STORE, 48'h6, 16'h8000, 1'b0);
		queue_txn(KIND_LOOKUP, 48'h6, '0, 1'b0);
		queue_txn(KIND_LOOKUP, 48'h7, '0, 1'b0);
		queue_txn(KIND_STORE, '1, '0, 1'b0);
		queue_txn(KIND_LOOKUP, '1, '1, 1'b0);

		for (int j = 0; j < 30; j++) begin
			pool.push_back(rand_key());
			if (j < 20)
				pool.push_back(cluster[j % 4] + KW'((j / 4) * 256 + (j % 4)));
			if (j < 8)
				pool.push_back(k63 + KW'((j + 3) * 256));
		end

		for (int n = 0; n < RANDOM_TXNS; n++) begin
			n_pool = (n / 6 + 12 < pool.size()) ? n / 6 + 12 : pool.size();
			pick = $urandom_range(0, 99);
			if (pick < 3)
				k = '0;
			else if (pick < 15)
				k = rand_key();
			else
				k = pool[$urandom_range(0, n_pool - 1)];
			queue_txn(($urandom_range(0, 99) < (n < 150 ? 65 : 45)) ? KIND_STORE : KIND_LOOKUP,
				k, 16'($urandom), $urandom_range(0, 3) == 0);
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (txn_queue.size() != 0 || in_valid || pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		errors += pending_results.size();
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
